>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SDAR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SDAR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sdar_pkg.sv
// Types and constants for the switch debounce and auto-repeat unit
`default_nettype none

package sdar_pkg;

	localparam int CHANNELS_DEF = 3;
	localparam int COUNT_W      = 8;
	localparam int LEVELS_W     = 3;
	localparam int CHAN_W       = 2;
	localparam int CFG_IDX_W    = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

	localparam logic [COUNT_W-1:0] PRESS_THRESHOLD_RST = 8'd3;
	localparam logic [COUNT_W-1:0] REPEAT_START_RST    = 8'd200;
	localparam logic [COUNT_W-1:0] REPEAT_STEP_RST     = 8'd10;

	localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_START    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_STEP     = 2'd2;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic [COUNT_W-1:0] press_threshold;
		logic [COUNT_W-1:0] repeat_start;
		logic [COUNT_W-1:0] repeat_step;
	} cfg_t;

	typedef struct packed {
		logic tick;
		logic query;
		logic level;
	} lane_ctl_t;

endpackage

`default_nettype wire

>>> rtl/sdar_lane.sv
// One channel's press counter with its tick update and query match
`default_nettype none

module sdar_lane
	import sdar_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire lane_ctl_t ctl,
	input  wire cfg_t      cfg,
	output logic           hit
);

	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_d;
	logic               at_thr;
	logic               at_rpt;

	always_comb begin
		at_thr  = (count_q == cfg.press_threshold);
		at_rpt  = (count_q >= cfg.repeat_start);
		hit     = at_thr || at_rpt;
		count_d = count_q;
		if (ctl.tick) begin
			if (!ctl.level)
				count_d = '0;
			else if (count_q != COUNT_MAX)
				count_d = count_q + 1'b1;
		end else if (ctl.query && !at_thr && at_rpt) begin
			// repeat report: pull the count back by one period, wrapping
			count_d = count_q - cfg.repeat_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else
			count_q <= count_d;
	end

endmodule

`default_nettype wire

>>> rtl/sdar_merge.sv
// Picks the queried lane's match out of all lanes
`default_nettype none

module sdar_merge
	import sdar_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
)
(
	input  wire logic [CHANNELS-1:0] hits,
	input  wire logic                is_query,
	input  wire logic [CHAN_W-1:0]   chan,
	output logic                     press_event
);

	logic found;

	// channels out of range match no lane and so report nothing
	always_comb begin
		found = 1'b0;
		for (int i = 0; i < CHANNELS; i++)
			found = found | (hits[i] & (int'(chan) == i));
		press_event = is_query & found;
	end

endmodule

`default_nettype wire

>>> rtl/sdar_outbuf.sv
// Output register with one skid entry
`default_nettype none

module sdar_outbuf
	import sdar_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic take,
	input  wire logic event_d,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	output logic      press_event
);

	logic out_valid_q;
	logic out_event_q;
	logic skid_valid_q;
	logic skid_event_q;
	logic out_free;

	assign out_free    = !out_valid_q || !out_stall;
	assign in_stall    = skid_valid_q;
	assign out_valid   = out_valid_q;
	assign press_event = out_event_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || take;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_event_q <= skid_valid_q ? skid_event_q : event_d;
		end else if (take) begin
			skid_event_q <= event_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/switch_debounce_auto_repeat_unit.sv
// Switch debounce with auto-repeat: top level
//
// Input channel (in_valid/in_stall) carries cmd, switch_levels and query_channel;
// an item is taken at an edge with in_valid high and in_stall low. A tick item
// (cmd 0) steps every channel's press counter and answers press_event 0. A
// query item (cmd 1) answers whether the chosen channel reports a press or a
// repeat. Every item gives exactly one result on out_valid/out_stall.
// One counter lane per channel updates in the accept cycle; the merge picks
// the queried lane. Results are registered in the output register or skid
// entry; one item per cycle is sustained while the receiver keeps out_stall low.
// When out_stall holds a result, one more item lands in a skid entry, then
// in_stall rises until the output drains.
// Configuration writes (cfg_valid/cfg_ready, cfg_ready always high) set the
// press threshold, repeat start and repeat step; write them only when idle.
// Reset (arst_n low) clears all counters and the output, and loads
// thresholds 3, 200 and step 10.
`default_nettype none

module switch_debounce_auto_repeat_unit
	import sdar_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
)
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 cmd,
	input  wire logic [LEVELS_W-1:0]  switch_levels,
	input  wire logic [CHAN_W-1:0]    query_channel,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      press_event,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COUNT_W-1:0]   cfg_data
);

	`include "assert_macros.svh"

	cfg_t                cfg_q;
	logic                accept;
	logic                is_query;
	logic [CHANNELS-1:0] hits;
	logic                event_d;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign is_query  = (cmd == CMD_QUERY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_threshold <= PRESS_THRESHOLD_RST;
			cfg_q.repeat_start    <= REPEAT_START_RST;
			cfg_q.repeat_step     <= REPEAT_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PRESS_THRESHOLD: cfg_q.press_threshold <= cfg_data;
				REG_REPEAT_START:    cfg_q.repeat_start    <= cfg_data;
				REG_REPEAT_STEP:     cfg_q.repeat_step     <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
		lane_ctl_t ctl;
		logic      level;

		// channels beyond the level field read as released
		if (i < LEVELS_W) begin : g_lvl
			assign level = switch_levels[i];
		end else begin : g_nolvl
			assign level = 1'b0;
		end

		assign ctl.tick  = accept && !is_query;
		assign ctl.query = accept && is_query && (int'(query_channel) == i);
		assign ctl.level = level;

		sdar_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.cfg    (cfg_q),
			.hit    (hits[i])
		);
	end

	sdar_merge #(
		.CHANNELS (CHANNELS)
	) u_merge (
		.hits        (hits),
		.is_query    (is_query),
		.chan        (query_channel),
		.press_event (event_d)
	);

	sdar_outbuf u_outbuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (accept),
		.event_d     (event_d),
		.in_stall    (in_stall),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.press_event (press_event)
	);

	`SDAR_ASSERT_IMP(a_skid_behind_out, clk, arst_n, in_stall, out_valid, "skid full with output empty")
	`SDAR_ASSERT_NXT(a_tick_silent, clk, arst_n, accept && (cmd == CMD_TICK) && !out_valid, out_valid && !press_event, "tick item gave a press")
	`SDAR_ASSERT_NXT(a_skid_fills, clk, arst_n, accept && out_valid && out_stall, in_stall, "item lost while output stalled")

endmodule

`default_nettype wire
